/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL. Each one is clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define AST_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// trigger in one cycle implies the condition in the following cycle
`define AST_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

/* hw/rtl/ifmr_pkg.sv */
// ----------------------------------------------------------------------------
// ifmr_pkg
// Types, table constants and constant functions for the initial-final mass
// relation block.
// ----------------------------------------------------------------------------
package ifmr_pkg;

  localparam int unsigned MASS_W       = 16;
  localparam int unsigned MODEL_W      = 2;
  localparam int unsigned TABLE_POINTS = 10;
  localparam int unsigned SEG_W        = 4;
  // wide enough for any fixed-point table constant at up to 16 fraction bits
  localparam int unsigned CONST_W      = 20;
  localparam int unsigned SLOPE_W      = 17;
  localparam int unsigned PROD_W       = SLOPE_W + MASS_W;
  localparam int unsigned SUM_W        = PROD_W + 1;
  // table segment slopes carry 16 fraction bits
  localparam int unsigned TAB_SLOPE_FRAC = 16;

  typedef enum logic [MODEL_W-1:0] {
    MODEL_TABLE     = 2'd0,
    MODEL_LINE_A    = 2'd1,
    MODEL_LINE_B    = 2'd2,
    MODEL_TWO_PIECE = 2'd3
  } model_t;

  typedef logic [TABLE_POINTS-1:0][CONST_W-1:0] tab_t;
  typedef logic [TABLE_POINTS-1:0][7:0]         pts_t;
  typedef logic [TABLE_POINTS-1:0][SLOPE_W-1:0] slope_tab_t;

  // initial masses in half solar masses, final masses in hundredths
  localparam pts_t INIT_HALVES = '{8'd18, 8'd16, 8'd14, 8'd12, 8'd10,
                                   8'd8,  8'd6,  8'd5,  8'd4,  8'd2};
  localparam pts_t FINAL_HUND  = '{8'd140, 8'd120, 8'd102, 8'd95, 8'd88,
                                   8'd80,  8'd68,  8'd63,  8'd60, 8'd55};

  // slope of segment k-1..k with 16 fraction bits, entry 0 unused
  localparam slope_tab_t SEG_SLOPE = '{17'd13107, 17'd11796, 17'd4588, 17'd4588,
                                       17'd5243,  17'd7864,  17'd6554, 17'd3932,
                                       17'd3277,  17'd0};

  // thousandths to fixed point, rounded to nearest
  function automatic logic [CONST_W-1:0] fx_milli(input logic [63:0] n,
                                                  input int unsigned f);
    logic [63:0] v;
    v = ((n << f) + 64'd500) / 64'd1000;
    return v[CONST_W-1:0];
  endfunction

  function automatic tab_t init_tab(input int unsigned f);
    tab_t t;
    for (int k = 0; k < TABLE_POINTS; k++) begin
      t[k] = CONST_W'(INIT_HALVES[k]) << (f - 1);
    end
    return t;
  endfunction

  function automatic tab_t final_tab(input int unsigned f);
    tab_t        t;
    logic [63:0] v;
    for (int k = 0; k < TABLE_POINTS; k++) begin
      v    = ((64'(FINAL_HUND[k]) << f) + 64'd50) / 64'd100;
      t[k] = v[CONST_W-1:0];
    end
    return t;
  endfunction

endpackage

/* hw/rtl/ifmr_in_if.sv */
// ----------------------------------------------------------------------------
// ifmr_in_if
// Input channel: valid/ready handshake carrying one initial mass.
// ----------------------------------------------------------------------------
interface ifmr_in_if;
  import ifmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] initial_mass;

  modport source (output valid, output initial_mass, input ready);
  modport sink   (input valid, input initial_mass, output ready);
endinterface

/* hw/rtl/ifmr_out_if.sv */
// ----------------------------------------------------------------------------
// ifmr_out_if
// Result channel: valid/ready handshake carrying one final mass.
// ----------------------------------------------------------------------------
interface ifmr_out_if;
  import ifmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] final_mass;

  modport source (output valid, output final_mass, input ready);
  modport sink   (input valid, input final_mass, output ready);
endinterface

/* hw/rtl/ifmr_eval.sv */
// ----------------------------------------------------------------------------
// ifmr_eval
// Combinational evaluation of the selected relation: segment lookup or line
// coefficients, one shared multiplier, rounding and saturation.
// ----------------------------------------------------------------------------
module ifmr_eval #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  ifmr_pkg::model_t          model,
  input  logic [ifmr_pkg::MASS_W-1:0] mass_in,
  output logic [ifmr_pkg::MASS_W-1:0] mass_out
);
  import ifmr_pkg::*;

  localparam tab_t INIT_FX  = init_tab(FRAC_BITS);
  localparam tab_t FINAL_FX = final_tab(FRAC_BITS);

  localparam logic [CONST_W-1:0] A_ICPT = fx_milli(64'd339, FRAC_BITS);
  localparam logic [CONST_W-1:0] A_SLP  = fx_milli(64'd129, FRAC_BITS);
  localparam logic [CONST_W-1:0] B_ICPT = fx_milli(64'd466, FRAC_BITS);
  localparam logic [CONST_W-1:0] B_SLP  = fx_milli(64'd84,  FRAC_BITS);
  localparam logic [CONST_W-1:0] C_ICPT = fx_milli(64'd331, FRAC_BITS);
  localparam logic [CONST_W-1:0] C_SLP  = fx_milli(64'd134, FRAC_BITS);
  localparam logic [CONST_W-1:0] D_ICPT = fx_milli(64'd679, FRAC_BITS);
  localparam logic [CONST_W-1:0] D_SLP  = fx_milli(64'd47,  FRAC_BITS);
  localparam logic [CONST_W-1:0] SPLIT_FX = CONST_W'(64'd4 << FRAC_BITS);

  localparam logic [PROD_W-1:0] HALF_TAB  = PROD_W'(1) << (TAB_SLOPE_FRAC - 1);
  localparam logic [PROD_W-1:0] HALF_LINE = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SEG_W-1:0]  SEG_LAST  = SEG_W'(TABLE_POINTS - 1);

  logic [CONST_W-1:0] m_ext;
  logic [SEG_W-1:0]   seg;
  logic [SEG_W-1:0]   seg_lo;
  logic [CONST_W-1:0] base;
  logic [SLOPE_W-1:0] mul_a;
  logic [MASS_W-1:0]  mul_b;
  logic               tab_shift;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  rnd;
  logic [SUM_W-1:0]   sum;

  assign m_ext  = CONST_W'(mass_in);
  assign seg_lo = seg - SEG_W'(1);

  // segment search: first inner point at or above the mass
  always_comb begin
    seg = SEG_LAST;
    for (int k = TABLE_POINTS - 2; k >= 1; k--) begin
      if (m_ext <= INIT_FX[k]) begin
        seg = SEG_W'(k);
      end
    end
  end

  // operand selection per relation
  always_comb begin
    base      = '0;
    mul_a     = '0;
    mul_b     = mass_in;
    tab_shift = 1'b0;
    unique case (model)
      MODEL_TABLE: begin
        tab_shift = 1'b1;
        if (m_ext <= INIT_FX[0]) begin
          base  = FINAL_FX[0];
        end else if (m_ext >= INIT_FX[TABLE_POINTS-1]) begin
          base  = FINAL_FX[TABLE_POINTS-1];
        end else begin
          base  = FINAL_FX[seg_lo];
          mul_a = SEG_SLOPE[seg];
          mul_b = MASS_W'(m_ext - INIT_FX[seg_lo]);
        end
      end
      MODEL_LINE_A: begin
        base  = A_ICPT;
        mul_a = SLOPE_W'(A_SLP);
      end
      MODEL_LINE_B: begin
        base  = B_ICPT;
        mul_a = SLOPE_W'(B_SLP);
      end
      MODEL_TWO_PIECE: begin
        if (m_ext > SPLIT_FX) begin
          base  = D_ICPT;
          mul_a = SLOPE_W'(D_SLP);
        end else begin
          base  = C_ICPT;
          mul_a = SLOPE_W'(C_SLP);
        end
      end
      default: begin
        base  = '0;
        mul_a = '0;
      end
    endcase
  end

  // shared multiply, round to nearest, saturate
  always_comb begin
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    if (tab_shift) begin
      rnd = (prod + HALF_TAB) >> TAB_SLOPE_FRAC;
    end else begin
      rnd = (prod + HALF_LINE) >> FRAC_BITS;
    end
    sum = SUM_W'(base) + SUM_W'(rnd);
    if (|sum[SUM_W-1:MASS_W]) begin
      mass_out = '1;
    end else begin
      mass_out = sum[MASS_W-1:0];
    end
  end

endmodule

/* hw/rtl/initial_final_mass_relation_top.sv */
// Pipeline: an accepted transaction passes through the input register, then
// the result register, where its result is presented as valid.
// Throughput: one transaction per cycle while the output is not stalled; the
// single multiplier in the evaluation stage is used once per item.
// Reset: rst_n synchronous, active low; clears both valid flags and sets the
// model register to table interpolation.
// ----------------------------------------------------------------------------
// initial_final_mass_relation_top
// Maps an initial stellar mass to a final white-dwarf mass under the
// configured relation, with a two-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
module initial_final_mass_relation_top #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ifmr_in_if.sink                      in_ch,
  ifmr_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [ifmr_pkg::MODEL_W-1:0] cfg_wdata
);
  import ifmr_pkg::*;

  `include "assert_macros.svh"

  model_t            model_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [MASS_W-1:0] mass_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [MASS_W-1:0] result_r;
  logic [MASS_W-1:0] result_c;
  logic              in_fire;
  logic              adv_out;

  // handshake and stage advance
  assign adv_out      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv_out;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (adv_out ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.final_mass = result_r;

  // relation evaluation
  ifmr_eval #(
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .model    (model_r),
    .mass_in  (mass_r),
    .mass_out (result_c)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r     <= MODEL_TABLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        model_r <= model_t'(cfg_wdata);
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mass_r <= in_ch.initial_mass;
    end
    if (s1_valid_r && adv_out) begin
      result_r <= result_c;
    end
  end

  // checks
  `AST_NEXT(a_in_to_s1, in_fire, s1_valid_r && mass_r == $past(in_ch.initial_mass))
  `AST_NEXT(a_s1_to_out, s1_valid_r && adv_out, out_valid_r && result_r == $past(result_c))
  `AST_NEXT(a_cfg_write, cfg_we, model_r == model_t'($past(cfg_wdata)))
  `AST_ALWAYS(a_no_accept_full, !(s1_valid_r && out_valid_r && !out_ch.ready && in_fire))

endmodule
